// ===== rtl/u2cal_pkg.sv =====
// Shared types, constants and helper functions for the seconds-to-calendar converter.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package u2cal_pkg;

  localparam int unsigned DEF_SECONDS_BITS = 32;
  localparam int unsigned EPOCH_IN_BITS    = 32;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned REM_BITS      = 17;

  // The day length is 675 shifted left by 7. The day count is the shifted count times
  // the rounded-up reciprocal of 675 scaled by 2^35, which is exact for 25-bit operands.
  localparam int unsigned DAY_SHIFT   = 7;
  localparam int unsigned RECIP_BITS  = 26;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;

  localparam int unsigned EPOCH_YEAR     = 1970;
  localparam int unsigned YEAR_DAYS      = 365;
  localparam int unsigned LEAP_YEAR_DAYS = 366;
  localparam int unsigned YLEN_BITS      = 9;

  // Position of 1970 inside the 4, 100 and 400 year cycles.
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;
  localparam logic [6:0] LAST_MOD100  = 7'd99;
  localparam logic [8:0] LAST_MOD400  = 9'd399;

  localparam logic [3:0] LAST_MONTH_IDX = 4'd11;
  localparam logic [3:0] FEB_IDX        = 4'd1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic split;
    logic cal_step;
    logic month_step;
    logic out_load;
  } u2cal_cmd_t;

  typedef struct packed {
    logic year_fit;
    logic tod_fit;
    logic month_fit;
  } u2cal_status_t;

  function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    case (idx)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/u2cal_dp.sv =====
// Datapath of the seconds-to-calendar converter: division by the day length through a
// reciprocal multiply, year, time-of-day and month stepping registers, and the result
// registers. Depends on u2cal_pkg; driven by commands from u2cal_ctrl.
`default_nettype none

module u2cal_dp
  import u2cal_pkg::*;
#(
  parameter int SECONDS_BITS = DEF_SECONDS_BITS
) (
  input  wire logic                     clk,
  input  wire logic [EPOCH_IN_BITS-1:0] epoch_seconds,
  input  wire u2cal_cmd_t               cmd,
  output u2cal_status_t                 status,
  output logic [11:0]                   year,
  output logic [3:0]                    month,
  output logic [4:0]                    day,
  output logic [4:0]                    hour,
  output logic [5:0]                    minute,
  output logic [5:0]                    second
);

  localparam int DAY_BITS  = SECONDS_BITS - 16;
  localparam int YEAR_BITS = DAY_BITS;
  localparam int HI_BITS   = EPOCH_IN_BITS - DAY_SHIFT;
  localparam int PROD_BITS = HI_BITS + RECIP_BITS;

  logic [EPOCH_IN_BITS-1:0] secs;
  logic [PROD_BITS-1:0]     day_prod;
  logic [EPOCH_IN_BITS-1:0] day_secs;
  logic [EPOCH_IN_BITS-1:0] tod_full;

  logic [DAY_BITS-1:0]  days;
  logic [YEAR_BITS-1:0] cur_year;
  logic [1:0]           mod4;
  logic [6:0]           mod100;
  logic [8:0]           mod400;
  logic [REM_BITS-1:0]  tod;
  logic [4:0]           hour_cnt;
  logic [5:0]           min_cnt;
  logic [3:0]           mon;

  logic                 leap;
  logic [YLEN_BITS-1:0] ylen;
  logic [4:0]           mlen;
  logic                 tod_ge_hour;
  logic                 tod_ge_min;

  assign day_prod = PROD_BITS'(secs[EPOCH_IN_BITS-1:DAY_SHIFT]) * PROD_BITS'(DAY_RECIP);
  assign day_secs = EPOCH_IN_BITS'(days) * EPOCH_IN_BITS'(SECS_PER_DAY);
  assign tod_full = secs - day_secs;

  assign leap = (mod400 == '0) || ((mod4 == '0) && (mod100 != '0));
  assign ylen = leap ? YLEN_BITS'(LEAP_YEAR_DAYS) : YLEN_BITS'(YEAR_DAYS);
  assign mlen = month_days(mon, leap);

  assign tod_ge_hour = tod >= REM_BITS'(SECS_PER_HOUR);
  assign tod_ge_min  = tod >= REM_BITS'(SECS_PER_MIN);

  assign status.year_fit  = days < DAY_BITS'(ylen);
  assign status.tod_fit   = !tod_ge_min;
  assign status.month_fit = (mon == LAST_MONTH_IDX) || (days < DAY_BITS'(mlen));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs <= epoch_seconds;
    end

    if (cmd.div_step) begin
      days <= DAY_BITS'(day_prod[PROD_BITS-1:RECIP_SHIFT]);
    end else if (cmd.split) begin
      tod      <= tod_full[REM_BITS-1:0];
      cur_year <= YEAR_BITS'(EPOCH_YEAR);
      mod4     <= EPOCH_MOD4;
      mod100   <= EPOCH_MOD100;
      mod400   <= EPOCH_MOD400;
      hour_cnt <= '0;
      min_cnt  <= '0;
      mon      <= '0;
    end else if (cmd.cal_step) begin
      if (!status.year_fit) begin
        days     <= days - DAY_BITS'(ylen);
        cur_year <= cur_year + 1'b1;
        mod4     <= mod4 + 1'b1;
        mod100   <= (mod100 == LAST_MOD100) ? '0 : mod100 + 1'b1;
        mod400   <= (mod400 == LAST_MOD400) ? '0 : mod400 + 1'b1;
      end
      if (tod_ge_hour) begin
        tod      <= tod - REM_BITS'(SECS_PER_HOUR);
        hour_cnt <= hour_cnt + 1'b1;
      end else if (tod_ge_min) begin
        tod     <= tod - REM_BITS'(SECS_PER_MIN);
        min_cnt <= min_cnt + 1'b1;
      end
    end else if (cmd.month_step) begin
      if (!status.month_fit) begin
        days <= days - DAY_BITS'(mlen);
        mon  <= mon + 1'b1;
      end
    end

    if (cmd.out_load) begin
      year   <= cur_year[11:0];
      month  <= mon + 1'b1;
      day    <= days[4:0] + 1'b1;
      hour   <= hour_cnt;
      minute <= min_cnt;
      second <= tod[5:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u2cal_ctrl.sv =====
// Controller of the seconds-to-calendar converter: sequences division, year and
// time-of-day stepping, month stepping and the result transfer.
// Depends on u2cal_pkg; commands u2cal_dp.
`default_nettype none

module u2cal_ctrl
  import u2cal_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          src_valid,
  output logic               src_stall,
  output logic               res_valid,
  input  wire logic          res_stall,
  input  wire u2cal_status_t status,
  output u2cal_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SPLIT,
    S_CAL,
    S_MONTH,
    S_DONE
  } state_t;

  state_t state;

  assign src_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && src_valid;
    cmd.div_step   = (state == S_DIV);
    cmd.split      = (state == S_SPLIT);
    cmd.cal_step   = (state == S_CAL);
    cmd.month_step = (state == S_MONTH);
    cmd.out_load   = (state == S_DONE) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (src_valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          state <= S_CAL;
        end
        S_CAL: begin
          if (status.year_fit && status.tod_fit) begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (status.month_fit) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/unix_time_to_calendar_core.sv =====
// Top level of the seconds-to-calendar converter: joins u2cal_ctrl and u2cal_dp.
// Depends on u2cal_pkg.
//
// Usage: the source channel (src_valid, src_stall, epoch_seconds) carries one count
// of seconds since 1970-01-01 00:00:00 UTC per transfer. The result channel
// (res_valid, res_stall, year .. second) carries the civil date and time for it,
// one result transfer per source transfer, in order.
// One item is converted at a time. After a source transfer the block finds the whole
// days by a reciprocal multiply, splits off the time of day, then steps the elapsed
// years and the hour and minute steps side by side (at most 82 hour and minute steps)
// until both fit, then steps the elapsed months, then loads the result register. The
// next item is taken only after the result register is loaded; for 32-bit counts the
// year stepping loop is the longest part of a conversion.
// src_stall is low only while the block is idle. A finished result sits in the
// output register; the next item is accepted and worked on while that result waits,
// and a new result is loaded only once the waiting one has been transferred.
// Reset (rst, synchronous) returns the controller to idle and drops res_valid.
`default_nettype none

module unix_time_to_calendar_core
  import u2cal_pkg::*;
#(
  parameter int SECONDS_BITS = DEF_SECONDS_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     src_valid,
  output logic                          src_stall,
  input  wire logic [EPOCH_IN_BITS-1:0] epoch_seconds,
  output logic                          res_valid,
  input  wire logic                     res_stall,
  output logic [11:0]                   year,
  output logic [3:0]                    month,
  output logic [4:0]                    day,
  output logic [4:0]                    hour,
  output logic [5:0]                    minute,
  output logic [5:0]                    second
);

  u2cal_cmd_t    cmd;
  u2cal_status_t status;

  u2cal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status   (status),
    .cmd      (cmd)
  );

  u2cal_dp #(
    .SECONDS_BITS(SECONDS_BITS)
  ) u_dp (
    .clk          (clk),
    .epoch_seconds(epoch_seconds),
    .cmd          (cmd),
    .status       (status),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

endmodule

`default_nettype wire

// ===== rtl/u2cal_checker.sv =====
// Port-level checks for the seconds-to-calendar converter, bound to its top level.
// Depends only on the ports of unix_time_to_calendar_core.
`default_nettype none

module u2cal_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        src_valid,
  input wire logic        src_stall,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [11:0] year,
  input wire logic [3:0]  month,
  input wire logic [4:0]  day,
  input wire logic [4:0]  hour,
  input wire logic [5:0]  minute,
  input wire logic [5:0]  second
);

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (src_valid && !src_stall) |=> src_stall)
    else $error("second source transfer while an item is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> res_valid && $stable(year) && $stable(month) &&
      $stable(day) && $stable(hour) && $stable(minute) && $stable(second))
    else $error("stalled result changed");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1 &&
      hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("result field out of range");

  a_month_length: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11))
      |-> day <= 5'd30 && (month != 4'd2 || day <= 5'd29))
    else $error("day beyond the length of a 30-day month");

endmodule

bind unix_time_to_calendar_core u2cal_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .src_valid(src_valid),
  .src_stall(src_stall),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .year     (year),
  .month    (month),
  .day      (day),
  .hour     (hour),
  .minute   (minute),
  .second   (second)
);

`default_nettype wire

// ===== verif/tb_unix_time_to_calendar_core.sv =====
// Testbench for unix_time_to_calendar_core: converts epoch second counts and checks each
// civil date and time against a predictor built in the bench, under random idling on
// both channels and a long result hold-off. Depends on u2cal_pkg and the core RTL.
module tb_unix_time_to_calendar_core;
  import u2cal_pkg::*;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  typedef struct packed {
    logic [31:0] secs;
    cal_t        cal;
  } stamp_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        typed;
    cal_t        want;
  } dir_row_t;

  localparam int N_DIR = 20;
  localparam int RANDOM_PER_PHASE = 630;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic [31:0] epoch_seconds = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  stamp_t   offered = '0;
  stamp_t   cal_q[$];
  dir_row_t dir_rows [N_DIR];
  int       snd_idle_pct = 0;
  int       rcv_idle_pct = 0;
  bit       hold_req = 1'b0;
  int       err_count = 0;
  int       n_accepted = 0;
  int       n_results = 0;

  unix_time_to_calendar_core dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .epoch_seconds(epoch_seconds),
    .res_valid(res_valid), .res_stall(res_stall),
    .year(year), .month(month), .day(day),
    .hour(hour), .minute(minute), .second(second)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout: %0d transfers accepted, %0d results seen", n_accepted, n_results);
    $display("Some tests failed");
    $finish;
  end

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return is_leap(y) ? LEAP_YEAR_DAYS : YEAR_DAYS;
  endfunction

  function automatic int unsigned month_length(input int m, input bit leap);
    case (m)
      1:       return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic cal_t civil_from_epoch(input logic [31:0] secs);
    longint unsigned days;
    longint unsigned tod;
    int unsigned     yr;
    int              m;
    bit              leap;
    cal_t            r;
    days = secs / SECS_PER_DAY;
    tod  = secs % SECS_PER_DAY;
    yr   = EPOCH_YEAR;
    while (days >= year_length(yr)) begin
      days = days - year_length(yr);
      yr++;
    end
    leap = is_leap(yr);
    m = 0;
    while (m < 11 && days >= month_length(m, leap)) begin
      days = days - month_length(m, leap);
      m++;
    end
    r.year   = yr[11:0];
    r.month  = 4'(m + 1);
    r.day    = 5'(days + 1);
    r.hour   = 5'(tod / SECS_PER_HOUR);
    r.minute = 6'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
    r.second = 6'(tod % SECS_PER_MIN);
    return r;
  endfunction

  // Day count from the epoch to the first of month m (0-based) of year y.
  function automatic longint days_to_month(input int unsigned y, input int m);
    longint d;
    d = 0;
    for (int unsigned yy = EPOCH_YEAR; yy < y; yy++) d += year_length(yy);
    for (int k = 0; k < m; k++) d += month_length(k, is_leap(y));
    return d;
  endfunction

  function automatic logic [31:0] random_epoch();
    int     kind;
    longint t;
    kind = $urandom_range(99);
    if (kind < 55) begin
      t = $urandom;
    end else if (kind < 72) begin
      t = days_to_month($urandom_range(1970, 2105), 0) * SECS_PER_DAY;
      t = t + $urandom_range(0, 4 * SECS_PER_DAY) - 2 * SECS_PER_DAY;
    end else if (kind < 85) begin
      t = days_to_month($urandom_range(1970, 2105), $urandom_range(1, 11)) * SECS_PER_DAY;
      t = t + $urandom_range(0, 4 * SECS_PER_DAY) - 2 * SECS_PER_DAY;
    end else if (kind < 95) begin
      t = $urandom_range(0, 400 * SECS_PER_DAY);
    end else begin
      t = 64'hFFFF_FFFF - $urandom_range(0, 60 * SECS_PER_DAY);
    end
    return t[31:0];
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] secs,
                             input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("epoch %0d: %s is %0d, expected %0d", secs, name, got, want));
  endtask

  // Scoreboard: retire the result transfer first, then record the source transfer.
  always @(posedge clk) begin : scoreboard
    stamp_t ex;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        n_results++;
        if (cal_q.size() == 0) begin
          flag_error($sformatf("result %0d-%0d-%0d with no expected value waiting",
                               year, month, day));
        end else begin
          ex = cal_q.pop_front();
          check_field("year", ex.secs, 32'(year), 32'(ex.cal.year));
          check_field("month", ex.secs, 32'(month), 32'(ex.cal.month));
          check_field("day", ex.secs, 32'(day), 32'(ex.cal.day));
          check_field("hour", ex.secs, 32'(hour), 32'(ex.cal.hour));
          check_field("minute", ex.secs, 32'(minute), 32'(ex.cal.minute));
          check_field("second", ex.secs, 32'(second), 32'(ex.cal.second));
        end
      end
      if (src_valid && !src_stall) begin
        cal_q.push_back(offered);
        n_accepted++;
      end
    end
  end

  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  task automatic offer_epoch(input logic [31:0] v, input cal_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      src_valid <= 1'b0;
      epoch_seconds <= $urandom;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    epoch_seconds <= v;
    offered <= '{secs: v, cal: want};
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] v;
    int          waited;
    dir_rows = '{
      '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
      '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}},
      '{32'd94694399,   1'b1, '{12'd1972, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
      '{32'd94694400,   1'b1, '{12'd1973, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
      '{32'd1,          1'b0, '0},
      '{32'd59,         1'b0, '0},
      '{32'd60,         1'b0, '0},
      '{32'd3599,       1'b0, '0},
      '{32'd3600,       1'b0, '0},
      '{32'd86399,      1'b0, '0},
      '{32'd86400,      1'b0, '0},
      '{32'd68169600,   1'b0, '0},
      '{32'd946684800,  1'b0, '0},
      '{32'd951782400,  1'b0, '0},
      '{32'd978220800,  1'b0, '0},
      '{32'd4107542399, 1'b0, '0},
      '{32'd4107542400, 1'b0, '0},
      '{32'h7FFF_FFFF,  1'b0, '0},
      '{32'h8000_0000,  1'b0, '0},
      '{32'h5555_5555,  1'b0, '0}
    };
    snd_idle_pct = 36;
    rcv_idle_pct = 50;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      offer_epoch(dir_rows[i].secs,
                  dir_rows[i].typed ? dir_rows[i].want : civil_from_epoch(dir_rows[i].secs));

    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 50 : 0;
      rcv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 36 : 0;
      // Hold results back for a long stretch so the core fills and stalls its input.
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        v = random_epoch();
        offer_epoch(v, civil_from_epoch(v));
      end
    end
    src_valid <= 1'b0;

    waited = 0;
    while (cal_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (cal_q.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", cal_q.size()));

    $display("Converted %0d timestamps (edges, leap days, century years, random) and",
             n_accepted);
    $display("checked %0d results under three idling mixes and one long result hold-off.",
             n_results);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
